### rtl/phtc_pkg.sv
// phtc_pkg: shared types and constants of the pivot heading controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package phtc_pkg;

  localparam int NUM_W = 35;  // rate squared plus rounding half
  localparam int DEN_W = 23;  // 200 * |error|

  localparam logic [16:0] DEF_SPEED  = 17'd29205;   // 2.8 rad/s
  localparam logic [16:0] DEF_ACCEL  = 17'd36506;   // 3.5 rad/s^2
  localparam logic [17:0] MIN_RATE   = 18'd5215;    // 0.5 rad/s
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;  // 2pi * 2^16
  localparam logic [17:0] INC_RECIP  = 18'd167773;  // ceil(2^24 / 100)
  localparam int          INC_SHIFT  = 24;

  localparam logic [1:0] CFG_SPEED  = 2'd0;
  localparam logic [1:0] CFG_ACCEL  = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  typedef struct packed {
    logic signed [17:0] w;
    logic               neg;    // error direction negative
    logic               decel;  // deceleration step taken
    logic               below;  // |w| under the speed limit
  } ctx_t;

  typedef struct packed {
    logic [16:0] speed;   // effective limits, defaults applied
    logic [16:0] accel;
    logic [9:0]  radius;
  } cfg_t;

  typedef struct packed {
    ctx_t             ctx;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    ctx_t             ctx;
    logic [NUM_W-1:0] quo;
  } div_out_t;

endpackage

### rtl/phtc_if.sv
// phtc_if: valid/ready channels for input items and result items.
// No dependencies.
`timescale 1ns / 1ps
interface phtc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading_now;
  logic signed [15:0] heading_goal;
  logic signed [17:0] rate_now;
  modport source(output valid, heading_now, heading_goal, rate_now, input ready);
  modport sink(input valid, heading_now, heading_goal, rate_now, output ready);
endinterface

interface phtc_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] rate_command;
  logic signed [14:0] side_velocity;
  modport source(output valid, rate_command, side_velocity, input ready);
  modport sink(input valid, rate_command, side_velocity, output ready);
endinterface

### rtl/pivot_heading_trapezoid_controller_core.sv
// pivot_heading_trapezoid_controller_core: top level of the pivot heading
// controller. Depends on phtc_pkg, phtc_if, phtc_front, phtc_div, phtc_back.
//
// Use:
//   cmd_in carries one item per control step: heading_now, heading_goal
//   (binary angles, 32768 = pi) and rate_now. cmd_out returns one result per
//   item, in order: rate_command (trapezoidal rate step, minimum magnitude
//   and speed clamp applied) and side_velocity (-radius * rate, mm/s).
//   Configuration: cfg_write with cfg_index 0 = speed_limit, 1 = accel_limit,
//   2 = pivot_radius; index 3 is ignored. Zero limits select the defaults
//   2.8 rad/s and 3.5 rad/s^2. Write only while no item is in flight.
// Timing:
//   43 register stages: 3 front stages, 35 divider stages (one quotient bit
//   each), 5 back stages. Throughput one item per cycle while cmd_out is
//   not stalled; the divider stage chain sets the depth.
// Reset:
//   rst (synchronous) clears all valid bits and the configuration registers to zero.
// Stall:
//   Each stage holds while the one after it is full and stalled; empty
//   stages keep filling, so cmd_in keeps taking items while results wait
//   until the whole pipeline is full.
`timescale 1ns / 1ps
module pivot_heading_trapezoid_controller_core (
  input  logic          clk,
  input  logic          rst,
  phtc_in_if.sink       cmd_in,
  phtc_out_if.source    cmd_out,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [16:0]   cfg_data
);
  import phtc_pkg::*;

  logic [16:0] speed_limit;
  logic [16:0] accel_limit;
  logic [9:0]  pivot_radius;
  cfg_t        cfg;

  logic     f_valid, f_ready;
  div_in_t  f_data;
  logic     d_valid, d_ready;
  div_out_t d_data;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit  <= '0;
      accel_limit  <= '0;
      pivot_radius <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SPEED:  speed_limit  <= cfg_data;
        CFG_ACCEL:  accel_limit  <= cfg_data;
        CFG_RADIUS: pivot_radius <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // effective limits, defaults substituted for zero
  always_comb begin
    cfg.speed  = (speed_limit == '0) ? DEF_SPEED : speed_limit;
    cfg.accel  = (accel_limit == '0) ? DEF_ACCEL : accel_limit;
    cfg.radius = pivot_radius;
  end

  phtc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .up_valid     (cmd_in.valid),
    .up_ready     (cmd_in.ready),
    .heading_now  (cmd_in.heading_now),
    .heading_goal (cmd_in.heading_goal),
    .rate_now     (cmd_in.rate_now),
    .dn_valid     (f_valid),
    .dn_ready     (f_ready),
    .dn_data      (f_data)
  );

  // q = (w^2 + 100|e|) / (200|e|)
  phtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_data  (d_data)
  );

  phtc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .up_valid      (d_valid),
    .up_ready      (d_ready),
    .up_data       (d_data),
    .dn_valid      (cmd_out.valid),
    .dn_ready      (cmd_out.ready),
    .rate_command  (cmd_out.rate_command),
    .side_velocity (cmd_out.side_velocity)
  );

  // command stays inside the speed limit
  a_cmd_clamped: assert property (@(posedge clk) disable iff (rst)
    cmd_out.valid |-> (cmd_out.rate_command <= $signed({1'b0, cfg.speed})) &&
                      (cmd_out.rate_command >= -$signed({1'b0, cfg.speed})))
    else $error("rate_command outside speed limit");

  // minimum magnitude keeps the command off zero
  a_cmd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd_out.valid |-> cmd_out.rate_command != 18'sd0)
    else $error("rate_command is zero");

  // side velocity opposes a positive rate
  a_side_sign: assert property (@(posedge clk) disable iff (rst)
    (cmd_out.valid && cmd_out.rate_command > 18'sd0) |-> cmd_out.side_velocity <= 15'sd0)
    else $error("side_velocity sign wrong");

  // nothing leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !cmd_out.valid)
    else $error("result valid after reset");
endmodule

### rtl/phtc_front.sv
// phtc_front: three stages; heading error, squares, deceleration test and
// divider operands. Depends on phtc_pkg.
`timescale 1ns / 1ps
module phtc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  phtc_pkg::cfg_t       cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [15:0]   heading_now,
  input  logic signed [15:0]   heading_goal,
  input  logic signed [17:0]   rate_now,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output phtc_pkg::div_in_t    dn_data
);
  import phtc_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // stage 1 registers
  ctx_t        ctx1;
  logic        toward1;
  logic [17:0] aw1;
  logic [15:0] ae1;
  // stage 2 registers
  ctx_t        ctx2;
  logic        toward2;
  logic [15:0] ae2;
  logic [34:0] sq2;
  logic [32:0] pa2;

  logic signed [15:0] err;
  logic [17:0]        aw;
  logic [15:0]        ae;
  logic [35:0]        sq_full;
  logic [39:0]        lhs, rhs;
  logic [DEN_W-1:0]   den;

  assign rdy3     = ~v3 | dn_ready;
  assign rdy2     = ~v2 | rdy3;
  assign rdy1     = ~v1 | rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3;

  always_comb begin
    err = 16'(heading_goal - heading_now);
    aw  = rate_now[17] ? 18'(-rate_now) : 18'(rate_now);
    ae  = err[15] ? 16'(-err) : 16'(err);
  end

  always_comb begin
    sq_full = 36'(aw1) * 36'(aw1);
  end

  always_comb begin
    lhs = ({5'b0, sq2} << 4) + ({5'b0, sq2} << 2);
    rhs = ({7'b0, pa2} << 5) + ({7'b0, pa2} << 2) + ({7'b0, pa2} << 1);
    den = (DEN_W'(ae2) << 7) + (DEN_W'(ae2) << 6) + (DEN_W'(ae2) << 3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ctx1.w     <= rate_now;
      ctx1.neg   <= err[15];
      ctx1.decel <= 1'b0;
      ctx1.below <= aw < {1'b0, cfg.speed};
      toward1    <= (rate_now != 18'sd0) && (err != 16'sd0) && (rate_now[17] == err[15]);
      aw1        <= aw;
      ae1        <= ae;
    end
    if (rdy2) begin
      ctx2    <= ctx1;
      toward2 <= toward1;
      ae2     <= ae1;
      sq2     <= sq_full[34:0];
      pa2     <= 33'(cfg.accel) * 33'(ae1);
    end
    if (rdy3) begin
      dn_data.ctx.w     <= ctx2.w;
      dn_data.ctx.neg   <= ctx2.neg;
      dn_data.ctx.below <= ctx2.below;
      dn_data.ctx.decel <= toward2 && (lhs > rhs);
      dn_data.num       <= sq2 + NUM_W'(den >> 1);
      dn_data.den       <= den;
    end
  end
endmodule

### rtl/phtc_div.sv
// phtc_div: restoring divider, one quotient bit per pipeline stage.
// Depends on phtc_pkg.
`timescale 1ns / 1ps
module phtc_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  phtc_pkg::div_in_t    up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output phtc_pkg::div_out_t   dn_data
);
  import phtc_pkg::*;

  typedef struct packed {
    ctx_t             ctx;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;   // numerator bits shift out, quotient bits in
    logic [DEN_W-1:0] den;
  } step_t;

  logic [NUM_W-1:0] v;
  logic [NUM_W:0]   rdy;
  step_t            st [NUM_W];

  assign rdy[NUM_W] = dn_ready;
  assign up_ready   = rdy[0];
  assign dn_valid   = v[NUM_W-1];
  assign dn_data.ctx = st[NUM_W-1].ctx;
  assign dn_data.quo = st[NUM_W-1].nq;

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    step_t        src;
    step_t        nxt;
    logic         src_v;
    logic [DEN_W:0] trial;

    if (k == 0) begin : g_first
      always_comb begin
        src.ctx = up_data.ctx;
        src.rem = '0;
        src.nq  = up_data.num;
        src.den = up_data.den;
      end
      assign src_v = up_valid;
    end else begin : g_next
      assign src   = st[k-1];
      assign src_v = v[k-1];
    end

    assign rdy[k] = ~v[k] | rdy[k+1];

    always_comb begin
      trial = {src.rem, src.nq[NUM_W-1]};
      nxt   = src;
      nxt.nq = {src.nq[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, src.den}) begin
        nxt.rem   = DEN_W'(trial - {1'b0, src.den});
        nxt.nq[0] = 1'b1;
      end else begin
        nxt.rem = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) st[k] <= nxt;
    end
  end
endmodule

### rtl/phtc_back.sv
// phtc_back: five stages; command select, minimum and clamp, side velocity.
// Depends on phtc_pkg.
`timescale 1ns / 1ps
module phtc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  phtc_pkg::cfg_t       cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  phtc_pkg::div_out_t   up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [17:0]   rate_command,
  output logic signed [14:0]   side_velocity
);
  import phtc_pkg::*;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  ctx_t               ctx1;
  logic [18:0]        qs1;
  logic [10:0]        inc1;
  logic signed [17:0] cmd2;
  logic               neg2;
  logic signed [17:0] cmd3;
  logic               pos3;
  logic [26:0]        p3;
  logic signed [17:0] cmd4;
  logic               pos4;
  logic [45:0]        m4;

  logic [35:0]        inc_prod;
  logic signed [19:0] c_sel, c_min, c_out, w20, s20;
  logic [19:0]        c_mag;
  logic [16:0]        acmd;
  logic [46:0]        rnd;
  logic [14:0]        qv;
  logic signed [14:0] sv;

  assign rdy5     = ~v5 | dn_ready;
  assign rdy4     = ~v4 | rdy5;
  assign rdy3     = ~v3 | rdy4;
  assign rdy2     = ~v2 | rdy3;
  assign rdy1     = ~v1 | rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v5;

  // (a + 50) / 100 by reciprocal
  assign inc_prod = 36'(18'(cfg.accel) + 18'd50) * 36'(INC_RECIP);

  always_comb begin
    w20 = 20'(ctx1.w);
    s20 = $signed({3'b0, cfg.speed});
    if (ctx1.decel) begin
      c_sel = ctx1.neg ? w20 + $signed({1'b0, qs1}) : w20 - $signed({1'b0, qs1});
    end else if (ctx1.below) begin
      c_sel = ctx1.neg ? w20 - $signed({9'b0, inc1}) : w20 + $signed({9'b0, inc1});
    end else begin
      c_sel = ctx1.neg ? -s20 : s20;
    end
    c_mag = c_sel[19] ? 20'(-c_sel) : 20'(c_sel);
    if (c_mag < 20'(MIN_RATE)) begin
      c_min = ctx1.neg ? -$signed(20'(MIN_RATE)) : $signed(20'(MIN_RATE));
    end else begin
      c_min = c_sel;
    end
    if (c_min > s20)       c_out = s20;
    else if (c_min < -s20) c_out = -s20;
    else                   c_out = c_min;
  end

  assign acmd = cmd2[17] ? 17'(-cmd2) : cmd2[16:0];

  always_comb begin
    rnd = {1'b0, m4} + (47'd1 << 31);
    qv  = rnd[46:32];
    if (pos4) sv = (qv > 15'd16384) ? -15'sd16384 : -$signed(qv);
    else      sv = (qv > 15'd16383) ? 15'sd16383 : $signed(qv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ctx1 <= up_data.ctx;
      // quotients past the rate range all clamp the same way
      qs1  <= (|up_data.quo[NUM_W-1:18]) ? 19'h40000 : {1'b0, up_data.quo[17:0]};
      inc1 <= inc_prod[INC_SHIFT+10:INC_SHIFT];
    end
    if (rdy2) begin
      cmd2 <= 18'(c_out);
      neg2 <= ctx1.neg;
    end
    if (rdy3) begin
      cmd3 <= cmd2;
      pos3 <= ~cmd2[17] && (cmd2 != 18'sd0) && ~neg2 | (~cmd2[17] && cmd2 != 18'sd0);
      p3   <= 27'(cfg.radius) * 27'(acmd);
    end
    if (rdy4) begin
      cmd4 <= cmd3;
      pos4 <= pos3;
      m4   <= 46'(p3) * 46'(TWO_PI_Q16);
    end
    if (rdy5) begin
      rate_command  <= cmd4;
      side_velocity <= sv;
    end
  end
endmodule

### test/testbench.sv
// testbench: self-checking test of the pivot heading controller core.
// Depends on phtc_pkg, phtc_if and pivot_heading_trapezoid_controller_core.
`timescale 1ns / 1ps
module testbench;
  import phtc_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  phtc_in_if  cmd_in();
  phtc_out_if cmd_out();

  pivot_heading_trapezoid_controller_core dut (
    .clk(clk), .rst(rst), .cmd_in(cmd_in), .cmd_out(cmd_out),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Pipeline depth from acceptance to result; drain adds a margin to it.
  localparam int LATENCY    = 43;
  localparam int CYCLE_CAP  = 400000;

  // Register index with no register behind it.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [17:0] rate_command;
    logic signed [14:0] side_velocity;
  } rate_cmd_t;

  // Local copy of the configuration registers, as the block should hold them.
  logic [16:0] speed_reg;
  logic [16:0] accel_reg;
  logic [9:0]  radius_reg;

  rate_cmd_t expected_cmds[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        errors;
  int        items_sent;
  int        results_seen;
  longint    cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Trapezoidal rate step, computed with 64-bit integers.
  function automatic rate_cmd_t predict_rate_cmd(logic signed [15:0] hdg_now,
                                                 logic signed [15:0] hdg_goal,
                                                 logic signed [17:0] rate_in);
    logic signed [15:0] err16;
    longint err, w, dir, spd, acc, aw, ae, cmd, den, quo, prod, vel;
    rate_cmd_t res;
    err16 = hdg_goal - hdg_now;
    err   = err16;
    w     = rate_in;
    dir   = (err < 0) ? -1 : 1;
    spd   = (speed_reg == 0) ? longint'(DEF_SPEED) : longint'(speed_reg);
    acc   = (accel_reg == 0) ? longint'(DEF_ACCEL) : longint'(accel_reg);
    aw    = (w < 0) ? -w : w;
    ae    = (err < 0) ? -err : err;
    if (((w > 0 && err > 0) || (w < 0 && err < 0)) && 20 * aw * aw > 38 * acc * ae) begin
      den = 200 * ae;
      quo = (aw * aw + den / 2) / den;
      cmd = w - dir * quo;
    end else if (aw < spd) begin
      cmd = w + dir * ((acc + 50) / 100);
    end else begin
      cmd = dir * spd;
    end
    if (((cmd < 0) ? -cmd : cmd) < longint'(MIN_RATE)) cmd = dir * longint'(MIN_RATE);
    if (cmd > spd) cmd = spd;
    if (cmd < -spd) cmd = -spd;
    prod = longint'(radius_reg) * ((cmd < 0) ? -cmd : cmd) * 411775;
    quo  = (prod + (longint'(1) << 31)) >>> 32;
    vel  = (cmd > 0) ? -quo : quo;
    if (vel > 16383) vel = 16383;
    if (vel < -16384) vel = -16384;
    res.rate_command  = cmd[17:0];
    res.side_velocity = vel[14:0];
    return res;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [16:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_SPEED:  speed_reg  = value;
      CFG_ACCEL:  accel_reg  = value;
      CFG_RADIUS: radius_reg = value[9:0];
      default: ;
    endcase
  endtask

  // Offer one item, with optional idle cycles before it; returns after it is taken.
  // valid stays high past acceptance until the next item or an idle cycle.
  task automatic send_heading(logic signed [15:0] hdg_now, logic signed [15:0] hdg_goal,
                              logic signed [17:0] rate_in);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_in.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_in.valid        <= 1'b1;
    cmd_in.heading_now  <= hdg_now;
    cmd_in.heading_goal <= hdg_goal;
    cmd_in.rate_now     <= rate_in;
    @(posedge clk);
    while (!cmd_in.ready) @(posedge clk);
    expected_cmds.push_back(predict_rate_cmd(hdg_now, hdg_goal, rate_in));
    items_sent++;
    @(negedge clk);
  endtask

  // Wait for the pipeline to empty so the registers may change.
  task automatic drain();
    cmd_in.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Receiver: ready toggles at random per the current idle rate.
  always @(negedge clk) begin
    if (rst) cmd_out.ready <= 1'b0;
    else cmd_out.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    rate_cmd_t want;
    cycles <= cycles + 1;
    if (!rst && cmd_out.valid && cmd_out.ready) begin
      results_seen <= results_seen + 1;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result rate=%0d side=%0d", $time,
                 cmd_out.rate_command, cmd_out.side_velocity);
        errors = errors + 1;
      end else begin
        want = expected_cmds.pop_front();
        if (want.rate_command !== cmd_out.rate_command) begin
          $display("%0t: rate_command expected %0d actual %0d", $time,
                   want.rate_command, cmd_out.rate_command);
          errors = errors + 1;
        end
        if (want.side_velocity !== cmd_out.side_velocity) begin
          $display("%0t: side_velocity expected %0d actual %0d", $time,
                   want.side_velocity, cmd_out.side_velocity);
          errors = errors + 1;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Extremes of all fields, zero error, -pi error, each of the three actions.
  task automatic test_directed();
    send_heading(16'sd0, 16'sd0, 18'sd0);              // zero error, positive direction
    send_heading(16'sd100, 16'sd100, 18'sd20000);      // zero error, no decel step
    send_heading(16'sd0, -16'sd32768, 18'sd0);         // error of -pi stays negative
    send_heading(-16'sd32768, 16'sd32767, -18'sd5);    // wrap to -1
    send_heading(16'sd32767, -16'sd32768, 18'sd5);     // wrap to +1
    send_heading(16'sd0, 16'sd10, 18'sd20000);         // strong decel
    send_heading(16'sd0, -16'sd10, -18'sd20000);
    send_heading(16'sd0, 16'sd20000, 18'sd1000);       // accelerate
    send_heading(16'sd0, -16'sd20000, -18'sd1000);
    send_heading(16'sd0, 16'sd20000, 18'sd131071);     // strong decel from full rate; the items below cruise
    send_heading(16'sd0, 16'sd20000, -18'sd131072);
    send_heading(16'sd0, -16'sd20000, 18'sd131071);
    send_heading(-16'sd32768, -16'sd32768, -18'sd131072);
    send_heading(16'sd32767, 16'sd32767, 18'sd131071);
    send_heading(16'sd0, 16'sd300, 18'sd100);          // minimum magnitude
    send_heading(16'sd0, -16'sd300, -18'sd100);
  endtask

  // Random items; mixes full-range values with small errors and near-limit rates.
  task automatic test_random(int count);
    logic signed [15:0] hn, err;
    logic signed [17:0] rt;
    for (int i = 0; i < count; i++) begin
      hn = 16'($urandom);
      case ($urandom_range(3))
        0: err = 16'($urandom);
        1: err = 16'($signed($urandom_range(400)) - 200);
        default: err = 16'($signed($urandom_range(8000)) - 4000);
      endcase
      case ($urandom_range(3))
        0: rt = 18'($urandom);
        1: rt = 18'($signed($urandom_range(80000)) - 40000);
        default: rt = 18'($signed($urandom_range(12000)) - 6000);
      endcase
      send_heading(hn, hn + err, rt);
    end
  endtask

  // One configuration setting, then a batch of items under it.
  task automatic test_setting(logic [16:0] spd, logic [16:0] acc, logic [9:0] rad,
                              int count);
    drain();
    write_reg(CFG_SPEED, spd);
    write_reg(CFG_ACCEL, acc);
    write_reg(CFG_RADIUS, {7'd0, rad});
    write_reg(CFG_UNUSED, 17'($urandom));  // ignored
    test_directed();
    test_random(count);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    cmd_in.valid        = 1'b0;
    cmd_in.heading_now  = '0;
    cmd_in.heading_goal = '0;
    cmd_in.rate_now     = '0;
    cmd_out.ready = 1'b0;
    speed_reg  = '0;
    accel_reg  = '0;
    radius_reg = '0;
    errors = 0; items_sent = 0; results_seen = 0; cycles = 0;
    send_idle_pct = 32;
    recv_idle_pct = 88;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_setting(17'd0, 17'd0, 10'd0, 60);            // defaults
    test_setting(17'd131071, 17'd131071, 10'd1023, 60);
    test_setting(17'd1, 17'd1, 10'd1, 40);            // limit below minimum rate
    send_idle_pct = 88;
    recv_idle_pct = 32;
    test_setting(17'd4000, 17'd500, 10'd512, 80);
    test_setting(17'($urandom), 17'($urandom), 10'($urandom), 120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_setting(17'd29205, 17'd36506, 10'd300, 200);
    test_setting(17'($urandom), 17'($urandom), 10'($urandom), 300);
    drain();

    $display("covered %0d items over 7 register settings, %0d results checked",
             items_sent, results_seen);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### pivot_heading_trapezoid_controller_core.f
rtl/phtc_pkg.sv
rtl/phtc_if.sv
rtl/phtc_front.sv
rtl/phtc_div.sv
rtl/phtc_back.sv
rtl/pivot_heading_trapezoid_controller_core.sv
test/testbench.sv
